[rtl/fcr_pkg.sv]
// Shared constants, codes and control types of the framed command core.
package fcr_pkg;

  // Field widths and sizing
  localparam int TOKEN_CAPACITY = 31;
  localparam int SAMPLE_BITS    = 12;
  localparam int KIND_W         = 2;
  localparam int BYTE_W         = 8;
  localparam int ADC_W          = 12;
  localparam int TIMEOUT_W      = 16;
  localparam int TLEN_W         = $clog2(TOKEN_CAPACITY + 1);
  localparam int HEAD_W         = 24;

  // Decimal digits needed for the widest sample: ceil(bits * log10(2)).
  localparam int DIGITS     = (SAMPLE_BITS * 30103 + 99999) / 100000;
  localparam int HDR_LEN    = 5;
  localparam int TAIL_LEN   = 3;
  localparam int PKT_MAX    = HDR_LEN + DIGITS + TAIL_LEN;
  localparam int IDX_W      = $clog2(PKT_MAX);
  localparam int HDR_IDX_W  = $clog2(HDR_LEN);
  localparam int DIG_IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int NDIG_W     = $clog2(DIGITS + 1);
  localparam int STEP_W     = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POLL = 2'd2;

  // Pending command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_RST  = 2'd1;
  localparam logic [1:0] CMD_OK   = 2'd2;

  // Sender phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SEND   = 2'd1;
  localparam logic [1:0] PH_WAIT   = 2'd2;
  localparam logic [1:0] PH_RESEND = 2'd3;

  // Characters
  localparam logic [BYTE_W-1:0] CH_BANG = 8'h21;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [3:0]        CH_DIGIT_HI = 4'h3;

  localparam logic [HEAD_W-1:0] TOK_RST = 24'h525354;
  localparam logic [HEAD_W-1:0] TOK_OK  = 24'h004F4B;

  localparam logic [BYTE_W-1:0] HDR_CHARS [HDR_LEN] = '{8'h21, 8'h41, 8'h44, 8'h43, 8'h3D};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             accept;
    logic             conv_load;
    logic             conv_step;
    logic             emit_load;
    logic [IDX_W-1:0] byte_idx;
  } fcr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic send_due;
    logic out_busy;
    logic emit_last;
  } fcr_stat_t;

endpackage

[rtl/fcr_if.sv]
// Channel interfaces: input items, result bytes and the configuration write.
interface fcr_in_if;
  import fcr_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] rx_byte;
  logic [ADC_W-1:0]  adc_sample;
  logic              adc_ok;
  modport source (output valid, kind, rx_byte, adc_sample, adc_ok, input ready);
  modport sink   (input valid, kind, rx_byte, adc_sample, adc_ok, output ready);
endinterface

interface fcr_out_if;
  import fcr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic              is_echo;
  logic              last;
  modport source (output valid, tx_byte, is_echo, last, input ready);
  modport sink   (input valid, tx_byte, is_echo, last, output ready);
endinterface

interface fcr_cfg_if;
  import fcr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/fcr_ctrl.sv]
// Controller: input handshake, digit conversion sequencing and packet byte sequencing.
module fcr_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [fcr_pkg::KIND_W-1:0]  in_kind,
  output logic                        in_ready,
  input  fcr_pkg::fcr_stat_t          stat,
  output fcr_pkg::fcr_cmd_t           cmd
);
  import fcr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // Items are taken only when idle and the result register can take a byte.
  assign in_ready = (state_r == ST_IDLE) && !stat.out_busy;

  // Next-state and command decode
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    idx_nxt        = idx_r;
    cmd.accept     = 1'b0;
    cmd.conv_load  = 1'b0;
    cmd.conv_step  = 1'b0;
    cmd.emit_load  = 1'b0;
    cmd.byte_idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid && in_ready;
        if (cmd.accept && in_kind == KIND_POLL && stat.send_due) begin
          cmd.conv_load = 1'b1;
          step_nxt      = '0;
          state_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (step_r == STEP_W'(SAMPLE_BITS - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[rtl/fcr_dp.sv]
// Datapath: frame parser, sender phase, elapsed counter, decimal conversion and result register.
module fcr_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fcr_pkg::KIND_W-1:0]     in_kind,
  input  logic [fcr_pkg::BYTE_W-1:0]     in_rx_byte,
  input  logic [fcr_pkg::ADC_W-1:0]      in_adc_sample,
  input  logic                           in_adc_ok,
  input  logic                           cfg_valid,
  input  logic [fcr_pkg::TIMEOUT_W-1:0]  cfg_data,
  output logic                           cfg_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fcr_pkg::BYTE_W-1:0]     out_tx_byte,
  output logic                           out_is_echo,
  output logic                           out_last,
  input  fcr_pkg::fcr_cmd_t              cmd,
  output fcr_pkg::fcr_stat_t             stat
);
  import fcr_pkg::*;

  logic [TIMEOUT_W-1:0]   timeout_r;
  logic                   in_frame_r, in_frame_nxt;
  logic [TLEN_W-1:0]      tok_len_r, tok_len_nxt;
  logic [HEAD_W-1:0]      tok_head_r, tok_head_nxt;
  logic [1:0]             pending_r, pending_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [TIMEOUT_W-1:0]   elapsed_r, elapsed_nxt;
  logic [SAMPLE_BITS-1:0] held_r, held_nxt;
  logic [SAMPLE_BITS-1:0] bin_r;
  logic [DIGITS-1:0][3:0] bcd_r, bcd_adj;
  logic                   out_valid_r;
  logic [BYTE_W-1:0]      tx_byte_r;
  logic                   is_echo_r, last_r;
  logic                   take_byte, take_tick, take_poll;
  logic [NDIG_W-1:0]      ndig;
  logic [IDX_W-1:0]       nd_x, digit_end, digit_pos, tail_off;
  logic [BYTE_W-1:0]      pkt_byte;

  assign take_byte = cmd.accept && (in_kind == KIND_BYTE);
  assign take_tick = cmd.accept && (in_kind == KIND_TICK);
  assign take_poll = cmd.accept && (in_kind == KIND_POLL);

  // The timeout register accepts every write.
  assign cfg_ready = 1'b1;

  // Frame parser, pending command, elapsed counter and sender phase
  always_comb begin
    in_frame_nxt = in_frame_r;
    tok_len_nxt  = tok_len_r;
    tok_head_nxt = tok_head_r;
    pending_nxt  = pending_r;
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    held_nxt     = held_r;
    if (take_byte) begin
      if (!in_frame_r) begin
        if (in_rx_byte == CH_BANG) begin
          in_frame_nxt = 1'b1;
          tok_len_nxt  = '0;
          tok_head_nxt = '0;
        end
      end else if (in_rx_byte == CH_HASH) begin
        if (tok_len_r == TLEN_W'(3) && tok_head_r == TOK_RST) begin
          pending_nxt = CMD_RST;
        end else if (tok_len_r == TLEN_W'(2) && tok_head_r == TOK_OK) begin
          pending_nxt = CMD_OK;
        end
        in_frame_nxt = 1'b0;
        tok_len_nxt  = '0;
        tok_head_nxt = '0;
      end else if (tok_len_r < TLEN_W'(TOKEN_CAPACITY)) begin
        // Only the first three characters are kept for matching.
        if (tok_len_r < TLEN_W'(3)) begin
          tok_head_nxt = {tok_head_r[HEAD_W-BYTE_W-1:0], in_rx_byte};
        end
        tok_len_nxt = tok_len_r + 1'b1;
      end
    end
    if (take_tick && elapsed_r != {TIMEOUT_W{1'b1}}) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end
    if (take_poll) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (pending_r == CMD_RST) begin
            pending_nxt = CMD_NONE;
            if (in_adc_ok) held_nxt = in_adc_sample[SAMPLE_BITS-1:0];
            phase_nxt = PH_SEND;
          end
        end
        PH_SEND, PH_RESEND: begin
          elapsed_nxt = '0;
          phase_nxt   = PH_WAIT;
        end
        PH_WAIT: begin
          if (pending_r == CMD_OK) begin
            pending_nxt = CMD_NONE;
            phase_nxt   = PH_IDLE;
          end else if (elapsed_r >= timeout_r) begin
            if (in_adc_ok) held_nxt = in_adc_sample[SAMPLE_BITS-1:0];
            phase_nxt = PH_RESEND;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Protocol and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RESET;
      in_frame_r <= 1'b0;
      tok_len_r  <= '0;
      tok_head_r <= '0;
      pending_r  <= CMD_NONE;
      phase_r    <= PH_IDLE;
      elapsed_r  <= '0;
      held_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_r <= cfg_data;
      in_frame_r <= in_frame_nxt;
      tok_len_r  <= tok_len_nxt;
      tok_head_r <= tok_head_nxt;
      pending_r  <= pending_nxt;
      phase_r    <= phase_nxt;
      elapsed_r  <= elapsed_nxt;
      held_r     <= held_nxt;
    end
  end

  // Shift-and-add-three adjustment, one sample bit per conversion step
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_load) begin
      bin_r <= held_r;
      bcd_r <= '0;
    end else if (cmd.conv_step) begin
      {bcd_r, bin_r} <= {bcd_adj, bin_r} << 1;
    end
  end

  // Number of significant digits, at least one
  always_comb begin
    ndig = NDIG_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) ndig = NDIG_W'(i + 1);
    end
  end

  // Packet byte at the requested position
  assign nd_x      = IDX_W'(ndig);
  assign digit_end = IDX_W'(HDR_LEN) + nd_x;
  assign digit_pos = digit_end - IDX_W'(1) - cmd.byte_idx;
  assign tail_off  = cmd.byte_idx - digit_end;

  always_comb begin
    if (cmd.byte_idx < IDX_W'(HDR_LEN)) begin
      pkt_byte = HDR_CHARS[cmd.byte_idx[HDR_IDX_W-1:0]];
    end else if (cmd.byte_idx < digit_end) begin
      pkt_byte = {CH_DIGIT_HI, bcd_r[digit_pos[DIG_IDX_W-1:0]]};
    end else begin
      case (tail_off)
        IDX_W'(0): pkt_byte = CH_HASH;
        IDX_W'(1): pkt_byte = CH_CR;
        default:   pkt_byte = CH_LF;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load || take_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      tx_byte_r <= pkt_byte;
      is_echo_r <= 1'b0;
      last_r    <= stat.emit_last;
    end else if (take_byte) begin
      tx_byte_r <= in_rx_byte;
      is_echo_r <= 1'b1;
      last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = tx_byte_r;
  assign out_is_echo = is_echo_r;
  assign out_last    = last_r;

  // Status to the controller
  assign stat.send_due  = phase_r[0];
  assign stat.out_busy  = out_valid_r && !out_ready;
  assign stat.emit_last = (cmd.byte_idx == digit_end + IDX_W'(TAIL_LEN - 1));

endmodule

[rtl/framed_command_request_ack_retry_core.sv]
// Top level of the framed command receiver with acknowledged packet sender.
//
// Channels: in_ch carries items (received byte, millisecond tick, poll step),
// out_ch carries transmitted bytes, cfg_ch writes the acknowledge timeout in
// milliseconds. Every channel moves a transfer when valid and ready are high.
// A received byte is echoed on out_ch in the cycle after its transfer; ticks,
// unused kinds and polls that send nothing give no result. A poll in the
// send or resend phase converts the held sample to decimal, one bit per cycle
// in the shift-and-add-three unit, then sends 9 to 12 packet bytes at one byte
// per cycle while out_ch does not stall; in_ch.ready stays low until the last
// packet byte is loaded. Otherwise one item is taken per cycle while out_ch drains.
// A single result register sits on out_ch: when the receiver stalls, the byte
// is held and no further item is taken until it leaves.
// Reset (rst_n low at a clock edge) clears the parser, the pending command,
// the sender phase, the counters and the held sample, and sets the timeout to
// 3000 ms. cfg_ch is always ready.
module framed_command_request_ack_retry_core (
  input logic       clk,
  input logic       rst_n,
  fcr_in_if.sink    in_ch,
  fcr_out_if.source out_ch,
  fcr_cfg_if.sink   cfg_ch
);
  import fcr_pkg::*;

  fcr_cmd_t  cmd;
  fcr_stat_t stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  // Sequencing
  fcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Protocol state and byte formation
  fcr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_ch.kind),
    .in_rx_byte    (in_ch.rx_byte),
    .in_adc_sample (in_ch.adc_sample),
    .in_adc_ok     (in_ch.adc_ok),
    .cfg_valid     (cfg_ch.valid),
    .cfg_data      (cfg_ch.data),
    .cfg_ready     (cfg_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_tx_byte   (out_ch.tx_byte),
    .out_is_echo   (out_ch.is_echo),
    .out_last      (out_ch.last),
    .cmd           (cmd),
    .stat          (stat)
  );

  // A received byte is offered as its own echo in the following cycle.
  a_echo_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.kind == KIND_BYTE) |=>
      (out_ch.valid && out_ch.is_echo && out_ch.last &&
       out_ch.tx_byte == $past(in_ch.rx_byte)))
    else $error("echo of a received byte missing or wrong");

  // A packet always closes with a line feed.
  a_packet_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_echo && out_ch.last) |-> (out_ch.tx_byte == CH_LF))
    else $error("packet ends on a byte other than line feed");

  // No item is taken while a packet is being formed or sent.
  a_no_take_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.conv_step || cmd.emit_load) |-> !in_ch.ready)
    else $error("item taken during a packet");

endmodule

[tb/fcr_tx_checker.sv]
// Transmit-side checker: predicts every transmitted byte of the core and compares it.
`timescale 1ns / 1ps

module fcr_tx_checker (
  input  logic clk,
  input  logic rst_n,
  fcr_in_if    in_ch,
  fcr_out_if   out_ch,
  fcr_cfg_if   cfg_ch,
  output int   mismatches,
  output int   awaited
);
  import fcr_pkg::*;

  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              is_echo;
    logic              last;
  } tx_beat_t;

  // Bytes the core still owes, oldest first.
  tx_beat_t tx_queue[$];

  // Mirror of the core's state and its one register.
  logic [TIMEOUT_W-1:0]   timeout_ms;
  logic                   framing;
  logic [TLEN_W-1:0]      tok_len;
  logic [HEAD_W-1:0]      tok_head;
  logic [1:0]             pend_cmd;
  logic [1:0]             phase;
  logic [TIMEOUT_W-1:0]   elapsed;
  logic [SAMPLE_BITS-1:0] held;

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    $display("%0t: mismatch on %s: got 0x%h, expected 0x%h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    tx_beat_t          want;
    logic [BYTE_W-1:0] pkt[$];
    logic [15:0]       v;
    string             hdr;

    if (!rst_n) begin
      timeout_ms = TIMEOUT_RESET;
      framing    = 1'b0;
      tok_len    = '0;
      tok_head   = '0;
      pend_cmd   = CMD_NONE;
      phase      = PH_IDLE;
      elapsed    = '0;
      held       = '0;
      tx_queue.delete();
    end else begin
      // Compare a result transfer with the oldest expected byte.
      if (out_ch.valid && out_ch.ready) begin
        if (tx_queue.size() == 0) begin
          report_mismatch("tx_byte with nothing expected", out_ch.tx_byte, '0);
        end else begin
          want = tx_queue.pop_front();
          if (out_ch.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", out_ch.tx_byte, want.tx_byte);
          if (out_ch.is_echo !== want.is_echo)
            report_mismatch("is_echo", 8'(out_ch.is_echo), 8'(want.is_echo));
          if (out_ch.last !== want.last)
            report_mismatch("last", 8'(out_ch.last), 8'(want.last));
        end
      end

      if (cfg_ch.valid && cfg_ch.ready)
        timeout_ms = cfg_ch.data;

      // Work out what an accepted item causes.
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.kind)
          KIND_BYTE: begin
            tx_queue.push_back('{in_ch.rx_byte, 1'b1, 1'b1});
            // Frame parser: everything between the opening and closing marks is token text.
            if (!framing) begin
              if (in_ch.rx_byte == CH_BANG) begin
                framing  = 1'b1;
                tok_len  = '0;
                tok_head = '0;
              end
            end else if (in_ch.rx_byte == CH_HASH) begin
              if (tok_len == 3 && tok_head == TOK_RST)
                pend_cmd = CMD_RST;
              else if (tok_len == 2 && tok_head == TOK_OK)
                pend_cmd = CMD_OK;
              framing  = 1'b0;
              tok_len  = '0;
              tok_head = '0;
            end else if (tok_len < TOKEN_CAPACITY) begin
              if (tok_len < 3)
                tok_head = {tok_head[HEAD_W-9:0], in_ch.rx_byte};
              tok_len++;
            end
          end
          KIND_TICK: begin
            if (elapsed != '1)
              elapsed++;
          end
          KIND_POLL: begin
            case (phase)
              PH_IDLE: begin
                if (pend_cmd == CMD_RST) begin
                  pend_cmd = CMD_NONE;
                  if (in_ch.adc_ok)
                    held = in_ch.adc_sample[SAMPLE_BITS-1:0];
                  phase = PH_SEND;
                end
              end
              PH_SEND, PH_RESEND: begin
                // Header, decimal digits most significant first, then the trailer.
                pkt.delete();
                hdr = "!ADC=";
                for (int i = 0; i < hdr.len(); i++)
                  pkt.push_back(hdr[i]);
                v = 16'(held);
                do begin
                  pkt.insert(hdr.len(), CH_ZERO + 8'(v % 10));
                  v = v / 10;
                end while (v != 0);
                pkt.push_back(CH_HASH);
                pkt.push_back(CH_CR);
                pkt.push_back(CH_LF);
                foreach (pkt[i])
                  tx_queue.push_back('{pkt[i], 1'b0, i == pkt.size() - 1});
                elapsed = '0;
                phase   = PH_WAIT;
              end
              default: begin
                if (pend_cmd == CMD_OK) begin
                  pend_cmd = CMD_NONE;
                  phase    = PH_IDLE;
                end else if (elapsed >= timeout_ms) begin
                  if (in_ch.adc_ok)
                    held = in_ch.adc_sample[SAMPLE_BITS-1:0];
                  phase = PH_RESEND;
                end
              end
            endcase
          end
          default: ;
        endcase
      end
    end
    awaited <= tx_queue.size();
  end

endmodule

[tb/tb_framed_command_request_ack_retry_core.sv]
// Testbench top: drives items, timeout writes and receiver stalls, and gives the verdict.
`timescale 1ns / 1ps

module tb_framed_command_request_ack_retry_core;
  import fcr_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
  localparam int                CYCLE_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   sent_items;
  int   cycle_count;
  int   mismatches;
  int   awaited;

  fcr_in_if  in_ch();
  fcr_out_if out_ch();
  fcr_cfg_if cfg_ch();

  framed_command_request_ack_retry_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  fcr_tx_checker u_tx_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stalls at random according to the current idle share.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic logic [ADC_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ADC_W'($urandom_range(4095));
    endcase
  endfunction

  // One item transfer; ready is sampled at the falling edge, where it is stable.
  task automatic put_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] rx,
                          input logic [ADC_W-1:0] sample, input logic ok);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.rx_byte    <= rx;
    in_ch.adc_sample <= sample;
    in_ch.adc_ok     <= ok;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      put_item(KIND_BYTE, s[i], pick_sample(), $urandom_range(1) == 1);
  endtask

  task automatic poll(input logic [ADC_W-1:0] sample, input logic ok);
    put_item(KIND_POLL, BYTE_W'($urandom_range(255)), sample, ok);
  endtask

  task automatic tick();
    put_item(KIND_TICK, BYTE_W'($urandom_range(255)), pick_sample(), $urandom_range(1) == 1);
  endtask

  // Hold the sender back until every expected byte has left, then let the core settle.
  task automatic wait_drained(input int settle);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
    bit taken;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ch.ready;
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed frames, polls and tick runs, with noise and broken frames mixed in.
  task automatic random_traffic(input int count);
    int                stop;
    int                r;
    int                n;
    logic [BYTE_W-1:0] c;
    string             letters;
    letters = "RSTOK";
    stop = sent_items + count;
    while (sent_items < stop) begin
      r = $urandom_range(99);
      if (r < 20) begin
        send_text("!RST#");
      end else if (r < 36) begin
        send_text("!OK#");
      end else if (r < 48) begin
        // Near-miss or overlong token; now and then the frame is left open.
        n = ($urandom_range(5) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 5);
        put_item(KIND_BYTE, CH_BANG, pick_sample(), 1'b1);
        repeat (n) begin
          if ($urandom_range(1) == 1) begin
            c = letters[$urandom_range(4)];
          end else begin
            c = BYTE_W'($urandom_range(255));
            if (c == CH_HASH)
              c = CH_BANG;
          end
          put_item(KIND_BYTE, c, pick_sample(), $urandom_range(1) == 1);
        end
        if ($urandom_range(7) != 0)
          put_item(KIND_BYTE, CH_HASH, pick_sample(), 1'b0);
      end else if (r < 74) begin
        repeat ($urandom_range(1, 3)) poll(pick_sample(), $urandom_range(3) != 0);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 12)) tick();
      end else if (r < 96) begin
        put_item(KIND_BYTE, BYTE_W'($urandom_range(255)), pick_sample(), 1'b0);
      end else begin
        put_item(KIND_SPARE, BYTE_W'($urandom_range(255)), pick_sample(),
                 $urandom_range(1) == 1);
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    sent_items       = 0;
    tx_idle_pct      = 27;
    rx_idle_pct      = 49;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_BYTE;
    in_ch.rx_byte    = '0;
    in_ch.adc_sample = '0;
    in_ch.adc_ok     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unused kind, byte extremes, idle poll, a held OK, a send and its acknowledge.
    put_item(KIND_SPARE, 8'hFF, 12'hFFF, 1'b1);
    put_item(KIND_BYTE, 8'h00, 12'h000, 1'b0);
    put_item(KIND_BYTE, 8'hFF, 12'hFFF, 1'b1);
    poll(12'hFFF, 1'b1);
    send_text("!OK#");
    poll(12'hFFF, 1'b1);
    send_text("!RST#");
    poll(12'hFFF, 1'b1);
    poll(12'h000, 1'b0);
    wait_drained(0);
    tick();
    tick();
    poll(12'h000, 1'b1);
    send_text("!OK#");
    poll(12'h000, 1'b1);
    wait_drained(8);

    // Zero timeout: every wait step without an acknowledge resends.
    write_timeout(16'd0);
    random_traffic(40);
    wait_drained(8);

    tx_idle_pct = 49;
    rx_idle_pct = 27;
    write_timeout(16'd1);
    random_traffic(35);
    wait_drained(8);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_timeout(TIMEOUT_W'($urandom_range(2, 8)));
    random_traffic(35);
    wait_drained(8);

    // Widest timeout: a short wait never resends.
    write_timeout(16'hFFFF);
    send_text("!OK#");
    repeat (3) poll(pick_sample(), 1'b1);
    send_text("!RST#");
    poll(pick_sample(), 1'b1);
    poll(pick_sample(), 1'b1);
    repeat (10) tick();
    poll(pick_sample(), 1'b1);
    poll(pick_sample(), 1'b1);
    send_text("!OK#");
    poll(pick_sample(), 1'b1);

    wait_drained(30);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
